// File: design/efd_pkg.sv
// Shared types and constants for the escaped frame deframer.
`timescale 1ns / 1ps

package efd_pkg;

    // Special byte values
    localparam logic [7:0] ESC_BYTE   = 8'h7D;
    localparam logic [7:0] ESC_XOR    = 8'h20;
    localparam logic [7:0] DELIM_BYTE = 8'h7E;
    localparam logic [7:0] SUM_GOOD   = 8'hFF;

    // Result kinds
    localparam logic [1:0] KIND_TYPE = 2'd0;
    localparam logic [1:0] KIND_DATA = 2'd1;
    localparam logic [1:0] KIND_END  = 2'd2;

    // Frame end status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_SUM = 2'd1;
    localparam logic [1:0] ST_BAD_LEN = 2'd2;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ESCAPED_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH   = 2'd1;
    localparam int unsigned CFG_DATA_W = 16;
    localparam logic [15:0] MAX_LENGTH_RESET = 16'd255;

    // Unescaped byte passed from the front end to the framer
    typedef struct packed {
        logic       is_delim;
        logic [7:0] data;
    } byte_item_t;

    // Framer phases, one-hot
    typedef enum logic [5:0] {
        PH_HUNT   = 6'b000001,
        PH_LEN_HI = 6'b000010,
        PH_LEN_LO = 6'b000100,
        PH_TYPE   = 6'b001000,
        PH_DATA   = 6'b010000,
        PH_CSUM   = 6'b100000
    } phase_t;

endpackage

// File: design/efd_unescape.sv
// Front end: accept raw bytes, strip escape sequences, tag delimiters.
`timescale 1ns / 1ps

module efd_unescape (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 escaped_mode,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_in_byte,
    input  logic                 q_full,
    output logic                 q_push,
    output efd_pkg::byte_item_t  q_push_data
);

    logic       escape_pending_reg;
    logic       escape_pending_next;
    logic       accept;
    logic       keep;
    logic [7:0] decoded;

    assign s_ready = !q_full;
    assign accept  = s_valid && !q_full;

    always_comb begin
        decoded             = s_in_byte;
        keep                = 1'b1;
        escape_pending_next = escape_pending_reg;
        if (accept) begin
            if (escaped_mode) begin
                if (escape_pending_reg) begin
                    decoded             = s_in_byte ^ efd_pkg::ESC_XOR;
                    escape_pending_next = 1'b0;
                end else if (s_in_byte == efd_pkg::ESC_BYTE) begin
                    // drop the escape byte itself
                    keep                = 1'b0;
                    escape_pending_next = 1'b1;
                end
            end else begin
                escape_pending_next = 1'b0;
            end
        end
    end

    assign q_push               = accept && keep;
    assign q_push_data.data     = decoded;
    assign q_push_data.is_delim = (decoded == efd_pkg::DELIM_BYTE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            escape_pending_reg <= 1'b0;
        end else begin
            escape_pending_reg <= escape_pending_next;
        end
    end

endmodule

// File: design/efd_fifo.sv
// Short queue of unescaped bytes between front end and framer.
`timescale 1ns / 1ps

module efd_fifo #(
    parameter int unsigned DEPTH = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  efd_pkg::byte_item_t  push_data,
    output logic                 full,
    input  logic                 pop,
    output logic                 empty,
    output efd_pkg::byte_item_t  pop_data
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    efd_pkg::byte_item_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == FULL_CNT);
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: design/efd_framer.sv
// Back end: frame state machine, checksum and registered result output.
`timescale 1ns / 1ps

module efd_framer (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [15:0]          max_length,
    input  logic                 q_empty,
    input  efd_pkg::byte_item_t  q_data,
    output logic                 q_pop,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [1:0]           m_result_kind,
    output logic [7:0]           m_out_byte,
    output logic [1:0]           m_frame_status
);

    efd_pkg::phase_t phase_reg, phase_next;
    logic [7:0]  length_high_reg, length_high_next;
    logic [15:0] bytes_left_reg,  bytes_left_next;
    logic [7:0]  sum_reg,         sum_next;
    logic        m_valid_reg,     m_valid_next;
    logic [1:0]  kind_reg,        kind_next;
    logic [7:0]  out_byte_reg,    out_byte_next;
    logic [1:0]  status_reg,      status_next;

    logic        advance;
    logic [15:0] len;
    logic        len_bad;
    logic [15:0] left_dec;
    logic [7:0]  sum_add;
    logic [7:0]  b;

    assign b        = q_data.data;
    assign advance  = !m_valid_reg || m_ready;
    assign q_pop    = !q_empty && advance;
    assign len      = {length_high_reg, b};
    assign len_bad  = (len == '0) || (len > max_length);
    assign left_dec = bytes_left_reg - 16'd1;
    assign sum_add  = sum_reg + b;

    always_comb begin
        phase_next       = phase_reg;
        length_high_next = length_high_reg;
        bytes_left_next  = bytes_left_reg;
        sum_next         = sum_reg;
        m_valid_next     = m_valid_reg;
        kind_next        = kind_reg;
        out_byte_next    = out_byte_reg;
        status_next      = status_reg;
        if (advance) begin
            m_valid_next = 1'b0;
        end
        if (q_pop) begin
            case (phase_reg)
                efd_pkg::PH_LEN_HI: begin
                    length_high_next = b;
                    phase_next       = efd_pkg::PH_LEN_LO;
                end
                efd_pkg::PH_LEN_LO: begin
                    if (len_bad) begin
                        // rescan both length bytes as possible delimiters
                        if (length_high_reg == efd_pkg::DELIM_BYTE) begin
                            length_high_next = b;
                            phase_next       = efd_pkg::PH_LEN_LO;
                        end else if (q_data.is_delim) begin
                            phase_next = efd_pkg::PH_LEN_HI;
                        end else begin
                            phase_next = efd_pkg::PH_HUNT;
                        end
                        m_valid_next  = 1'b1;
                        kind_next     = efd_pkg::KIND_END;
                        out_byte_next = '0;
                        status_next   = efd_pkg::ST_BAD_LEN;
                    end else begin
                        bytes_left_next = len - 16'd1;
                        sum_next        = '0;
                        phase_next      = efd_pkg::PH_TYPE;
                    end
                end
                efd_pkg::PH_TYPE: begin
                    sum_next      = b;
                    phase_next    = (bytes_left_reg == '0) ? efd_pkg::PH_CSUM
                                                           : efd_pkg::PH_DATA;
                    m_valid_next  = 1'b1;
                    kind_next     = efd_pkg::KIND_TYPE;
                    out_byte_next = b;
                    status_next   = efd_pkg::ST_OK;
                end
                efd_pkg::PH_DATA: begin
                    sum_next        = sum_add;
                    bytes_left_next = left_dec;
                    if (left_dec == '0) begin
                        phase_next = efd_pkg::PH_CSUM;
                    end
                    m_valid_next  = 1'b1;
                    kind_next     = efd_pkg::KIND_DATA;
                    out_byte_next = b;
                    status_next   = efd_pkg::ST_OK;
                end
                efd_pkg::PH_CSUM: begin
                    sum_next      = sum_add;
                    phase_next    = efd_pkg::PH_HUNT;
                    m_valid_next  = 1'b1;
                    kind_next     = efd_pkg::KIND_END;
                    out_byte_next = '0;
                    status_next   = (sum_add == efd_pkg::SUM_GOOD) ? efd_pkg::ST_OK
                                                                   : efd_pkg::ST_BAD_SUM;
                end
                default: begin
                    phase_next = q_data.is_delim ? efd_pkg::PH_LEN_HI : efd_pkg::PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= efd_pkg::PH_HUNT;
            length_high_reg <= '0;
            bytes_left_reg  <= '0;
            sum_reg         <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            phase_reg       <= phase_next;
            length_high_reg <= length_high_next;
            bytes_left_reg  <= bytes_left_next;
            sum_reg         <= sum_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg     <= kind_next;
        out_byte_reg <= out_byte_next;
        status_reg   <= status_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_result_kind  = kind_reg;
    assign m_out_byte     = out_byte_reg;
    assign m_frame_status = status_reg;

endmodule

// File: design/escaped_frame_deframer.sv
// Top level of the escaped frame deframer: config registers and datapath wiring.
`timescale 1ns / 1ps

//  channel   | direction | handshake          | payload
//  ----------+-----------+--------------------+------------------------------------------
//  s_ (in)   | in        | s_valid / s_ready  | s_in_byte[7:0]
//  m_ (out)  | out       | m_valid / m_ready  | m_result_kind, m_out_byte, m_frame_status
//  cfg       | in        | cfg_we             | cfg_index, cfg_wdata
//
//  One raw byte is taken per cycle while the queue has room; one result leaves per cycle
//  while m_ready is high. An accepted byte is written to the queue; the framer pops it
//  once older bytes are gone and its output register is free, and loads any result for it
//  into that register. The output register is the only back-pressure point for the
//  framer; the front end keeps accepting until the queue (QUEUE_DEPTH entries) fills.
//  Reset clears the framer to hunting, drops any pending escape and empties the queue.

module escaped_frame_deframer #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // raw byte input
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [7:0]                     s_in_byte,
    // results
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [1:0]                     m_result_kind,
    output logic [7:0]                     m_out_byte,
    output logic [1:0]                     m_frame_status,
    // configuration write port
    input  logic                           cfg_we,
    input  logic [efd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [efd_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    // Configuration registers; writes to unknown indexes fall through.
    logic        escaped_mode_reg;
    logic [15:0] max_length_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            escaped_mode_reg <= 1'b0;
            max_length_reg   <= efd_pkg::MAX_LENGTH_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                efd_pkg::CFG_ESCAPED_MODE: escaped_mode_reg <= cfg_wdata[0];
                efd_pkg::CFG_MAX_LENGTH:   max_length_reg   <= cfg_wdata[15:0];
                default: begin
                end
            endcase
        end
    end

    // Front end -> queue -> framer
    logic                q_push;
    efd_pkg::byte_item_t q_push_data;
    logic                q_full;
    logic                q_pop;
    logic                q_empty;
    efd_pkg::byte_item_t q_pop_data;

    // Strip escapes and flag delimiters as bytes arrive.
    efd_unescape u_unescape (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .escaped_mode (escaped_mode_reg),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_in_byte    (s_in_byte),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_push_data  (q_push_data)
    );

    // Decouple acceptance from result back-pressure.
    efd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .pop_data  (q_pop_data)
    );

    // Walk the frame: length check, type/data pass-through, checksum verdict.
    efd_framer u_framer (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .max_length     (max_length_reg),
        .q_empty        (q_empty),
        .q_data         (q_pop_data),
        .q_pop          (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_kind  (m_result_kind),
        .m_out_byte     (m_out_byte),
        .m_frame_status (m_frame_status)
    );

endmodule
